// ===== sv/ed1g_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ed1g_pkg
// Shared types and constants of the edit-distance-one candidate generator.
// ----------------------------------------------------------------------------
package ed1g_pkg;

   localparam int unsigned WORD_CHARS     = 15;
   localparam int unsigned CAND_CHARS     = 16;
   localparam int unsigned MAX_WORD_CHARS = 15;
   localparam int unsigned ALPHABET_SIZE  = 26;
   localparam logic [7:0]  FIRST_LETTER   = 8'h61;

   localparam int unsigned LETTER_BITS    = $clog2(ALPHABET_SIZE);

   typedef enum logic [1:0] {
      OP_DELETE    = 2'd0,
      OP_TRANSPOSE = 2'd1,
      OP_REPLACE   = 2'd2,
      OP_INSERT    = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
   } status_type;

endpackage : ed1g_pkg
`default_nettype wire

// ===== sv/ed1g_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ed1g_ctrl
// Sequencer: takes a command, then walks the result beats of one word.
// ----------------------------------------------------------------------------
module ed1g_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output logic                     rsp_strobe,
   output ed1g_pkg::cmd_type        cmd,
   input  wire ed1g_pkg::status_type status
);
   import ed1g_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b0;
      rsp_strobe  = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_strobe = 1'b1;
            if (status.last) begin
               // next command is taken alongside the final beat
               if (start) begin
                  cmd.load = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               busy        = 1'b1;
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : ed1g_ctrl
`default_nettype wire

// ===== sv/ed1g_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ed1g_datapath
// Holds the word and the edit, steps the letter and forms each candidate.
// ----------------------------------------------------------------------------
module ed1g_datapath (
   input  wire logic                 clock,
   input  wire ed1g_pkg::cmd_type    cmd,
   output ed1g_pkg::status_type      status,
   input  wire logic [63:0]          req_word_low,
   input  wire logic [55:0]          req_word_high,
   input  wire logic [3:0]           req_word_length,
   input  wire logic [1:0]           req_operation,
   input  wire logic [3:0]           req_split_position,
   output logic      [63:0]          rsp_cand_low,
   output logic      [63:0]          rsp_cand_high,
   output logic      [4:0]           rsp_cand_length,
   output logic                      rsp_cand_valid,
   output logic                      rsp_last_of_run
);
   import ed1g_pkg::*;

   logic [7:0]             word_ff [CAND_CHARS];
   logic [7:0]             word_in [CAND_CHARS];
   op_type                 op_ff;
   logic [3:0]             split_ff;
   logic [4:0]             length_ff, length_in;
   logic                   invalid_ff, invalid_in;
   logic [LETTER_BITS-1:0] letter_idx_ff;

   logic [7:0]             wx [CAND_CHARS+2];
   logic [7:0]             cand [CAND_CHARS];
   logic [7:0]             letter;
   op_type                 op_req;
   logic [4:0]             len_req;
   logic [4:0]             split_req;

   // latch the word with bytes beyond its length cleared; check the edit and form the length
   always_comb begin
      op_req    = op_type'(req_operation);
      len_req   = {1'b0, req_word_length};
      split_req = {1'b0, req_split_position};
      for (int k = 0; k < CAND_CHARS; k++) begin
         if (k < 8) begin
            word_in[k] = req_word_low[8*k +: 8];
         end else if (k < WORD_CHARS) begin
            word_in[k] = req_word_high[8*(k-8) +: 8];
         end else begin
            word_in[k] = 8'h00;
         end
         if (5'(k) >= len_req) begin
            word_in[k] = 8'h00;
         end
      end

      invalid_in = (len_req > 5'(MAX_WORD_CHARS)) || (split_req > len_req) ||
                   ((op_req == OP_DELETE) && (split_req >= len_req)) ||
                   ((op_req == OP_TRANSPOSE) && (split_req + 5'd1 >= len_req));

      case (op_req)
         OP_DELETE:    length_in = len_req - 5'd1;
         OP_TRANSPOSE: length_in = len_req;
         OP_REPLACE:   length_in = (split_req < len_req) ? len_req : len_req + 5'd1;
         OP_INSERT:    length_in = len_req + 5'd1;
         default:      length_in = len_req;
      endcase
      if (invalid_in) begin
         length_in = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff       <= word_in;
         op_ff         <= op_req;
         split_ff      <= req_split_position;
         length_ff     <= length_in;
         invalid_ff    <= invalid_in;
         letter_idx_ff <= '0;
      end else if (cmd.advance) begin
         letter_idx_ff <= letter_idx_ff + 1'b1;
      end
   end

   assign status.last = invalid_ff || (op_ff == OP_DELETE) || (op_ff == OP_TRANSPOSE) ||
                        (letter_idx_ff == LETTER_BITS'(ALPHABET_SIZE - 1));

   assign letter = FIRST_LETTER + 8'(letter_idx_ff);

   // wx[k+1] is word byte k, with a zero on either side
   always_comb begin
      wx[0]            = 8'h00;
      wx[CAND_CHARS+1] = 8'h00;
      for (int k = 0; k < CAND_CHARS; k++) begin
         wx[k+1] = word_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < CAND_CHARS; k++) begin
         case (op_ff)
            OP_DELETE: begin
               cand[k] = (5'(k) < {1'b0, split_ff}) ? wx[k+1] : wx[k+2];
            end
            OP_TRANSPOSE: begin
               if (5'(k) == {1'b0, split_ff}) begin
                  cand[k] = wx[k+2];
               end else if (5'(k) == {1'b0, split_ff} + 5'd1) begin
                  cand[k] = wx[k];
               end else begin
                  cand[k] = wx[k+1];
               end
            end
            OP_REPLACE: begin
               cand[k] = (5'(k) == {1'b0, split_ff}) ? letter : wx[k+1];
            end
            OP_INSERT: begin
               if (5'(k) < {1'b0, split_ff}) begin
                  cand[k] = wx[k+1];
               end else if (5'(k) == {1'b0, split_ff}) begin
                  cand[k] = letter;
               end else begin
                  cand[k] = wx[k];
               end
            end
            default: begin
               cand[k] = wx[k+1];
            end
         endcase
         if (invalid_ff) begin
            cand[k] = 8'h00;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rsp_cand_low[8*k +: 8]  = cand[k];
         rsp_cand_high[8*k +: 8] = cand[k+8];
      end
   end

   assign rsp_cand_length = length_ff;
   assign rsp_cand_valid  = ~invalid_ff;
   assign rsp_last_of_run = status.last;

endmodule : ed1g_datapath
`default_nettype wire

// ===== sv/edit_distance_one_generator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// edit_distance_one_generator_core
// Emits the edit-distance-one candidates of one word for one split and edit.
//
//   channel   ports                        handshake
//   command   req_*                        beat taken when start & !busy
//   result    rsp_*                        one beat per cycle on rsp_strobe
//
// Delete and transpose give one result beat, the cycle after the command.
// Replace and insert give 26 beats on consecutive cycles, one per letter,
// paced by the letter counter in the datapath; an invalid command gives a single beat.
// busy is low in idle and on the final beat, so commands can run back to back.
// Synchronous reset returns the sequencer to idle; no beat is in flight.
// The receiver cannot stall: every beat stands for exactly one cycle.
// ----------------------------------------------------------------------------
module edit_distance_one_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_word_low,
   input  wire logic [55:0] req_word_high,
   input  wire logic [3:0]  req_word_length,
   input  wire logic [1:0]  req_operation,
   input  wire logic [3:0]  req_split_position,
   output logic             rsp_strobe,
   output logic      [63:0] rsp_cand_low,
   output logic      [63:0] rsp_cand_high,
   output logic      [4:0]  rsp_cand_length,
   output logic             rsp_cand_valid,
   output logic             rsp_last_of_run
);
   import ed1g_pkg::*;

   cmd_type    cmd;
   status_type status;

   ed1g_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   ed1g_datapath u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_word_low       (req_word_low),
      .req_word_high      (req_word_high),
      .req_word_length    (req_word_length),
      .req_operation      (req_operation),
      .req_split_position (req_split_position),
      .rsp_cand_low       (rsp_cand_low),
      .rsp_cand_high      (rsp_cand_high),
      .rsp_cand_length    (rsp_cand_length),
      .rsp_cand_valid     (rsp_cand_valid),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule : edit_distance_one_generator_core
`default_nettype wire

// ===== tb/ed1g_checker.sv =====
// ----------------------------------------------------------------------------
// ed1g_checker
// Watches the command and result channels of the candidate generator. Each
// accepted command beat is expanded into the candidate words it must produce,
// and every result beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module ed1g_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [63:0] req_word_low,
   input  wire logic [55:0] req_word_high,
   input  wire logic [3:0]  req_word_length,
   input  wire logic [1:0]  req_operation,
   input  wire logic [3:0]  req_split_position,
   input  wire logic        rsp_strobe,
   input  wire logic [63:0] rsp_cand_low,
   input  wire logic [63:0] rsp_cand_high,
   input  wire logic [4:0]  rsp_cand_length,
   input  wire logic        rsp_cand_valid,
   input  wire logic        rsp_last_of_run,
   output int               errors,
   output int               pending
);
   import ed1g_pkg::*;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
      logic [4:0]  length;
      logic        valid;
      logic        last;
   } cand_type;

   typedef logic [7:0] cand_bytes_type [CAND_CHARS+1];

   cand_type expected_cands [$];

   function automatic void add_expected(input cand_type cand);
      expected_cands.insert(expected_cands.size(), cand);
   endfunction

   // bytes at or beyond the candidate length stay zero
   function automatic cand_type pack_cand(input cand_bytes_type c, input int unsigned len,
                                          input logic valid, input logic last);
      cand_type r;
      r.low    = '0;
      r.high   = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < len) r.low[8*k +: 8] = c[k];
         if (k + 8 < len) r.high[8*k +: 8] = c[k+8];
      end
      r.length = len[4:0];
      r.valid  = valid;
      r.last   = last;
      return r;
   endfunction

   function automatic void predict_candidates(input logic [63:0] wl, input logic [55:0] wh,
                                              input logic [3:0] wlen, input op_type op,
                                              input logic [3:0] split);
      logic [7:0]     w [CAND_CHARS];
      cand_bytes_type c;
      int unsigned    len;
      int unsigned    sp;
      int unsigned    clen;
      len = wlen;
      sp  = split;
      for (int k = 0; k < CAND_CHARS; k++) begin
         if (k < 8) w[k] = wl[8*k +: 8];
         else if (k < WORD_CHARS) w[k] = wh[8*(k-8) +: 8];
         else w[k] = 8'h00;
      end
      foreach (c[k]) c[k] = 8'h00;

      if (len > MAX_WORD_CHARS || sp > len ||
          (op == OP_DELETE && sp >= len) || (op == OP_TRANSPOSE && sp + 1 >= len)) begin
         add_expected(pack_cand(c, 0, 1'b0, 1'b1));
         return;
      end

      case (op)
         OP_DELETE: begin
            for (int k = 0; k < sp; k++) c[k] = w[k];
            for (int k = sp + 1; k < len; k++) c[k-1] = w[k];
            add_expected(pack_cand(c, len - 1, 1'b1, 1'b1));
         end
         OP_TRANSPOSE: begin
            for (int k = 0; k < len; k++) c[k] = w[k];
            c[sp]   = w[sp+1];
            c[sp+1] = w[sp];
            add_expected(pack_cand(c, len, 1'b1, 1'b1));
         end
         default: begin
            for (int n = 0; n < ALPHABET_SIZE; n++) begin
               foreach (c[k]) c[k] = 8'h00;
               for (int k = 0; k < sp; k++) c[k] = w[k];
               c[sp] = FIRST_LETTER + 8'(n);
               if (op == OP_REPLACE) begin
                  for (int k = sp + 1; k < len; k++) c[k] = w[k];
                  // replace at the end split appends the letter
                  clen = (sp < len) ? len : len + 1;
               end else begin
                  for (int k = sp; k < len; k++) c[k+1] = w[k];
                  clen = len + 1;
               end
               add_expected(pack_cand(c, clen, 1'b1, n == ALPHABET_SIZE - 1));
            end
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      cand_type want;
      if (reset) begin
         expected_cands.delete();
         errors  = 0;
         pending = 0;
      end else begin
         // compare before predicting: a new command never yields a beat the same cycle
         if (rsp_strobe) begin
            if (expected_cands.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %h_%h len %0d",
                        $time, rsp_cand_high, rsp_cand_low, rsp_cand_length);
               errors++;
            end else begin
               want = expected_cands.pop_front();
               check_field("cand_low", want.low, rsp_cand_low);
               check_field("cand_high", want.high, rsp_cand_high);
               check_field("cand_length", 64'(want.length), 64'(rsp_cand_length));
               check_field("cand_valid", 64'(want.valid), 64'(rsp_cand_valid));
               check_field("last_of_run", 64'(want.last), 64'(rsp_last_of_run));
            end
         end
         if (start && !busy)
            predict_candidates(req_word_low, req_word_high, req_word_length,
                               op_type'(req_operation), req_split_position);
         pending = expected_cands.size();
      end
   end

endmodule : ed1g_checker

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives edit commands into the candidate generator: a directed set over the
// length and split extremes and every edit kind, then random words in three
// pacing phases. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import ed1g_pkg::*;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int RANDOM_ITEMS   = 107;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_word_low;
   logic [55:0] req_word_high;
   logic [3:0]  req_word_length;
   logic [1:0]  req_operation;
   logic [3:0]  req_split_position;
   logic        rsp_strobe;
   logic [63:0] rsp_cand_low;
   logic [63:0] rsp_cand_high;
   logic [4:0]  rsp_cand_length;
   logic        rsp_cand_valid;
   logic        rsp_last_of_run;

   int errors;
   int pending;
   int idle_pct;
   int quiet_cycles;

   edit_distance_one_generator_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_word_low       (req_word_low),
      .req_word_high      (req_word_high),
      .req_word_length    (req_word_length),
      .req_operation      (req_operation),
      .req_split_position (req_split_position),
      .rsp_strobe         (rsp_strobe),
      .rsp_cand_low       (rsp_cand_low),
      .rsp_cand_high      (rsp_cand_high),
      .rsp_cand_length    (rsp_cand_length),
      .rsp_cand_valid     (rsp_cand_valid),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   ed1g_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_word_low       (req_word_low),
      .req_word_high      (req_word_high),
      .req_word_length    (req_word_length),
      .req_operation      (req_operation),
      .req_split_position (req_split_position),
      .rsp_strobe         (rsp_strobe),
      .rsp_cand_low       (rsp_cand_low),
      .rsp_cand_high      (rsp_cand_high),
      .rsp_cand_length    (rsp_cand_length),
      .rsp_cand_valid     (rsp_cand_valid),
      .rsp_last_of_run    (rsp_last_of_run),
      .errors             (errors),
      .pending            (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // cycles in which neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic logic [63:0] random_word64(input bit letters_only);
      logic [63:0] v;
      for (int k = 0; k < 8; k++)
         v[8*k +: 8] = letters_only ? FIRST_LETTER + 8'($urandom_range(ALPHABET_SIZE - 1))
                                    : 8'($urandom);
      return v;
   endfunction

   task automatic send_command(input logic [63:0] wl, input logic [55:0] wh,
                               input logic [3:0] wlen, input op_type op,
                               input logic [3:0] split);
      // each offered cycle is left idle with the phase's odds
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start              = 1'b0;
         req_word_low       = {$urandom, $urandom};
         req_word_high      = 56'({$urandom, $urandom});
         req_word_length    = 4'($urandom);
         req_operation      = 2'($urandom);
         req_split_position = 4'($urandom);
      end
      @(negedge clock);
      start              = 1'b1;
      req_word_low       = wl;
      req_word_high      = wh;
      req_word_length    = wlen;
      req_operation      = op;
      req_split_position = split;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold commands off until every expected beat has come back
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic send_random_command();
      bit          letters;
      logic [3:0]  wlen;
      logic [3:0]  split;
      letters = $urandom_range(9) < 7;
      wlen    = 4'($urandom_range(MAX_WORD_CHARS));
      // mostly splits inside the word, some beyond its end
      split   = ($urandom_range(99) < 88) ? 4'($urandom_range(wlen)) : 4'($urandom);
      send_command(random_word64(letters), 56'(random_word64(letters)), wlen,
                   op_type'($urandom_range(3)), split);
   endtask

   initial begin
      op_type op;
      start              = 1'b0;
      reset              = 1'b1;
      req_word_low       = '0;
      req_word_high      = '0;
      req_word_length    = '0;
      req_operation      = OP_DELETE;
      req_split_position = '0;
      idle_pct           = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty word, full word at both ends, every edit kind
      for (int i = 0; i < 4; i++) begin
         op = op_type'(i);
         send_command('0, '0, 4'd0, op, 4'd0);
         send_command('1, '1, 4'd15, op, 4'd0);
         send_command('1, '1, 4'd15, op, 4'd15);
      end
      send_command(64'h0807_0605_0403_0201, 56'h0f0e_0d0c_0b0a_09, 4'd15, OP_TRANSPOSE, 4'd14);
      send_command(64'h0807_0605_0403_0201, 56'h0f0e_0d0c_0b0a_09, 4'd15, OP_TRANSPOSE, 4'd13);
      send_command(64'h0807_0605_0403_0201, 56'h0f0e_0d0c_0b0a_09, 4'd15, OP_DELETE, 4'd14);
      // split past the end of the word
      send_command(64'h6463_6261, '0, 4'd3, OP_REPLACE, 4'd9);
      send_command('1, '1, 4'd0, OP_INSERT, 4'd15);
      // garbage beyond the length must be ignored
      send_command(64'ha5a5_a56f_6c6c_6568, '1, 4'd5, OP_REPLACE, 4'd2);
      send_command(64'ha5a5_a56f_6c6c_6568, '1, 4'd5, OP_INSERT, 4'd5);
      send_command(64'hffff_ffff_ffff_7978, '1, 4'd2, OP_TRANSPOSE, 4'd0);
      send_command(64'hffff_ffff_ffff_ff71, '1, 4'd1, OP_DELETE, 4'd0);
      send_command(64'hffff_ffff_ffff_ff71, '1, 4'd1, OP_REPLACE, 4'd0);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 33 : (phase == 1) ? 74 : 0;
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_random_command();
            if ($urandom_range(39) == 0) drain_results();
         end
         drain_results();
      end

      repeat (40) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule : tb
